// File: src/skyba_pkg.sv
`default_nettype none

package skyba_pkg;

    localparam int DEF_PAGE_WIDTH  = 128;
    localparam int DEF_PAGE_HEIGHT = 128;
    localparam int DEF_MAX_PAGES   = 256;

    // Working width for size compares; covers every parameter value up to 1023 and a sum of two.
    localparam int DW = 11;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OPEN,
        ST_CALC,
        ST_READ,
        ST_DRAIN,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic col_zero;
        logic first_page;
    } colmax_ctrl_t;

endpackage

`default_nettype wire

// File: src/skyline_block_allocator.sv
// Skyline block allocator.
// The input channel s_axis carries one allocation request per item: block width and
// height. The result channel m_axis returns one item per request: page index, x, y,
// the placed flag and the number of pages opened so far.
// Column heights of the live page sit in a RAM of PAGE_WIDTH words, each tagged with
// the page it was written on, so opening a page needs no clearing pass. After reset
// the block sweeps the RAM once, one word a cycle, before s_axis_tready first rises.
// One placement attempt runs through the cursor step, a read pass over the block's
// columns through the shared maximum unit, a drain step while the last RAM read
// returns, the height check and a write pass over the same columns. An attempt that
// fails stops after the check, and the block opens a new page, if one is left, and
// tries again. Refused and oversized requests go straight to the result step.
// One request is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the next request is accepted while it
// waits; if the receiver stalls and a second result is ready, the block holds it
// until m_axis_tready frees the register.
`default_nettype none

module skyline_block_allocator import skyba_pkg::*; #(
    parameter int PAGE_WIDTH  = DEF_PAGE_WIDTH,
    parameter int PAGE_HEIGHT = DEF_PAGE_HEIGHT,
    parameter int MAX_PAGES   = DEF_MAX_PAGES
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // block_width [7:0], block_height [15:8]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // page_index [7:0], pos_x [14:8], pos_y [21:15], placed [22], pages_used [31:23]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(PAGE_WIDTH);
    localparam int CW = $clog2(PAGE_WIDTH + 1);
    localparam int HW = $clog2(PAGE_HEIGHT + 1);
    localparam int TW = $clog2(MAX_PAGES + 1);

    state_t state_reg, state_next;

    logic [7:0]    w_reg, w_next;
    logic [7:0]    h_reg, h_next;
    logic [AW-1:0] x_reg, x_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic          reverse_reg, reverse_next;
    logic [TW-1:0] open_reg, open_next;
    logic          res_placed_reg, res_placed_next;
    logic [HW-1:0] res_y_reg, res_y_next;
    logic          m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic          rd_valid_reg;
    logic          rd_zero_reg;

    logic [7:0]    in_w, in_h;
    logic          in_zero, in_oversize;
    logic          can_open;
    logic          out_free;
    logic [DW-1:0] cur_ext, w_ext, step_cur, step_x;
    logic          step_rev;
    logic [HW-1:0] max_height;
    logic [DW-1:0] fit_sum;
    logic          fits;
    logic [HW-1:0] new_height;
    logic [DW-1:0] open_ext, page_ext, x_ext, y_ext;

    logic              ram_we;
    logic [HW+TW-1:0]  ram_wdata, ram_rdata;
    colmax_ctrl_t      cm_ctrl;

    assign in_w        = s_axis_tdata[7:0];
    assign in_h        = s_axis_tdata[15:8];
    assign in_zero     = (in_w == 8'd0) || (in_h == 8'd0);
    assign in_oversize = ({3'b000, in_w} > DW'(PAGE_WIDTH)) ||
                         ({3'b000, in_h} > DW'(PAGE_HEIGHT));
    assign can_open    = DW'(open_reg) < DW'(MAX_PAGES);
    assign out_free    = !m_valid_reg || m_axis_tready;

    assign cur_ext = DW'(cursor_reg);
    assign w_ext   = DW'(w_reg);

    always_comb begin
        if (reverse_reg) begin
            if (cur_ext < w_ext) begin
                step_rev = 1'b0;
                step_x   = '0;
                step_cur = w_ext;
            end else begin
                step_rev = 1'b1;
                step_cur = cur_ext - w_ext;
                step_x   = cur_ext - w_ext;
            end
        end else begin
            if (cur_ext + w_ext > DW'(PAGE_WIDTH)) begin
                step_rev = 1'b1;
                step_cur = DW'(PAGE_WIDTH) - w_ext;
                step_x   = DW'(PAGE_WIDTH) - w_ext;
            end else begin
                step_rev = 1'b0;
                step_x   = cur_ext;
                step_cur = cur_ext + w_ext;
            end
        end
    end

    assign fit_sum    = DW'(max_height) + DW'(h_reg);
    assign fits       = fit_sum <= DW'(PAGE_HEIGHT);
    assign new_height = HW'(DW'(res_y_reg) + DW'(h_reg));

    assign open_ext = DW'(open_reg);
    assign page_ext = open_ext - DW'(1);
    assign x_ext    = DW'(x_reg);
    assign y_ext    = DW'(res_y_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == AW'(PAGE_WIDTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_zero || in_oversize) begin
                        state_next = ST_DONE;
                    end else if (open_reg == '0) begin
                        state_next = ST_OPEN;
                    end else begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_OPEN:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_READ;
            ST_READ: begin
                if (cnt_reg == 8'd1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_CHECK;
            ST_CHECK: begin
                if (fits) begin
                    state_next = ST_WRITE;
                end else if (can_open) begin
                    state_next = ST_OPEN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                if (cnt_reg == 8'd1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        w_next          = w_reg;
        h_next          = h_reg;
        x_next          = x_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        cursor_next     = cursor_reg;
        reverse_next    = reverse_reg;
        open_next       = open_reg;
        res_placed_next = res_placed_reg;
        res_y_next      = res_y_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;
        ram_wdata       = {open_reg, new_height};
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = AW'(addr_reg + AW'(1));
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_next          = in_w;
                    h_next          = in_h;
                    res_placed_next = 1'b0;
                    if (!in_zero && in_oversize && can_open) begin
                        open_next    = TW'(MAX_PAGES);
                        reverse_next = 1'b0;
                        cursor_next  = ((MAX_PAGES == 1) && (open_reg == '0)) ? CW'(1) : '0;
                    end
                end
            end
            ST_OPEN: begin
                open_next    = TW'(open_reg + TW'(1));
                reverse_next = 1'b0;
                cursor_next  = (open_reg == '0) ? CW'(1) : '0;
            end
            ST_CALC: begin
                reverse_next = step_rev;
                cursor_next  = CW'(step_cur);
                x_next       = AW'(step_x);
                addr_next    = AW'(step_x);
                cnt_next     = w_reg;
            end
            ST_READ: begin
                addr_next = AW'(addr_reg + AW'(1));
                cnt_next  = cnt_reg - 8'd1;
            end
            ST_DRAIN: begin
            end
            ST_CHECK: begin
                if (fits) begin
                    res_placed_next = 1'b1;
                    res_y_next      = max_height;
                    addr_next       = x_reg;
                    cnt_next        = w_reg;
                end else begin
                    res_placed_next = 1'b0;
                end
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                addr_next = AW'(addr_reg + AW'(1));
                cnt_next  = cnt_reg - 8'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (res_placed_reg) begin
                        m_data_next = {open_ext[8:0], 1'b1, y_ext[6:0], x_ext[6:0],
                                       page_ext[7:0]};
                    end else begin
                        m_data_next = {open_ext[8:0], 23'd0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            cursor_reg   <= '0;
            reverse_reg  <= 1'b0;
            open_reg     <= '0;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            cursor_reg   <= cursor_next;
            reverse_reg  <= reverse_next;
            open_reg     <= open_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge aclk) begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        x_reg          <= x_next;
        res_placed_reg <= res_placed_next;
        res_y_reg      <= res_y_next;
        m_data_reg     <= m_data_next;
        rd_zero_reg    <= (addr_reg == '0);
    end

    skyba_ram #(
        .WIDTH (HW + TW),
        .DEPTH (PAGE_WIDTH)
    ) u_heights (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign cm_ctrl.clear      = (state_reg == ST_CALC);
    assign cm_ctrl.valid      = rd_valid_reg;
    assign cm_ctrl.col_zero   = rd_zero_reg;
    assign cm_ctrl.first_page = (open_reg == TW'(1));

    skyba_colmax #(
        .HW (HW),
        .TW (TW)
    ) u_colmax (
        .aclk       (aclk),
        .ctrl       (cm_ctrl),
        .cur_tag    (open_reg),
        .rd_tag     (ram_rdata[HW+TW-1:HW]),
        .rd_height  (ram_rdata[HW-1:0]),
        .max_height (max_height)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: src/skyba_ram.sv
`default_nettype none

module skyba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/skyba_colmax.sv
`default_nettype none

module skyba_colmax import skyba_pkg::*; #(
    parameter int HW = 8,
    parameter int TW = 9
) (
    input  wire logic         aclk,
    input  wire colmax_ctrl_t ctrl,
    input  wire logic [TW-1:0] cur_tag,
    input  wire logic [TW-1:0] rd_tag,
    input  wire logic [HW-1:0] rd_height,
    output logic      [HW-1:0] max_height
);

    logic [HW-1:0] max_reg;
    logic [HW-1:0] max_next;
    logic [HW-1:0] col_value;

    // A column written on an earlier page reads as cleared; the first page reserves texel (0,0).
    always_comb begin
        if (rd_tag == cur_tag) begin
            col_value = rd_height;
        end else if (ctrl.col_zero && ctrl.first_page) begin
            col_value = HW'(1);
        end else begin
            col_value = '0;
        end
    end

    always_comb begin
        max_next = max_reg;
        if (ctrl.clear) begin
            max_next = '0;
        end else if (ctrl.valid && (col_value > max_reg)) begin
            max_next = col_value;
        end
    end

    always_ff @(posedge aclk) begin
        max_reg <= max_next;
    end

    assign max_height = max_reg;

endmodule

`default_nettype wire

// File: dv/tb_skyline_block_allocator.sv
module tb_skyline_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import skyba_pkg::*;

    localparam int PAGE_W          = DEF_PAGE_WIDTH;
    localparam int PAGE_H          = DEF_PAGE_HEIGHT;
    localparam int PAGE_LIMIT      = DEF_MAX_PAGES;
    localparam int STALL_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 900;
    localparam int SETTLE_CYCLES   = 600;

    typedef struct packed {
        logic [8:0] pages_used;
        logic       placed;
        logic [6:0] pos_y;
        logic [6:0] pos_x;
        logic [7:0] page_index;
    } alloc_result_t;

    typedef struct packed {
        logic [7:0]    width;
        logic [7:0]    height;
        logic          fixed_result;
        alloc_result_t result;
    } request_row_t;

    localparam alloc_result_t REFUSED_FRESH = '0;
    localparam alloc_result_t FIRST_TEXEL   = '{pages_used: 9'd1, placed: 1'b1, pos_y: 7'd0,
                                                pos_x: 7'd1, page_index: 8'd0};
    localparam alloc_result_t PAGES_SPENT   = '{pages_used: 9'd256, placed: 1'b0, pos_y: 7'd0,
                                                pos_x: 7'd0, page_index: 8'd0};

    localparam int N_OPENING = 15;
    localparam int N_ROWS    = 21;

    localparam request_row_t REQUEST_ROWS [N_ROWS] = '{
        '{8'd0,   8'd5,   1'b1, REFUSED_FRESH},
        '{8'd5,   8'd0,   1'b1, REFUSED_FRESH},
        '{8'd0,   8'd0,   1'b1, REFUSED_FRESH},
        '{8'd1,   8'd1,   1'b1, FIRST_TEXEL},
        '{8'd127, 8'd1,   1'b0, '0},
        '{8'd128, 8'd128, 1'b0, '0},
        '{8'd1,   8'd128, 1'b0, '0},
        '{8'd128, 8'd1,   1'b0, '0},
        '{8'd127, 8'd127, 1'b0, '0},
        '{8'd64,  8'd64,  1'b0, '0},
        '{8'd64,  8'd64,  1'b0, '0},
        '{8'd0,   8'd9,   1'b0, '0},
        '{8'd1,   8'd1,   1'b0, '0},
        '{8'd85,  8'd42,  1'b0, '0},
        '{8'd42,  8'd85,  1'b0, '0},
        '{8'd255, 8'd255, 1'b1, PAGES_SPENT},
        '{8'd129, 8'd1,   1'b1, PAGES_SPENT},
        '{8'd1,   8'd129, 1'b1, PAGES_SPENT},
        '{8'd128, 8'd128, 1'b0, '0},
        '{8'd1,   8'd1,   1'b0, '0},
        '{8'd128, 8'd1,   1'b0, '0}
    };

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned send_gap_pct     = 0;
    int unsigned take_gap_pct     = 0;
    bit          hold_off_pending = 1'b0;
    int          failures         = 0;
    int unsigned requests_taken   = 0;
    int unsigned placed_seen      = 0;
    int unsigned unplaced_seen    = 0;
    int unsigned quiet_cycles     = 0;

    alloc_result_t placements_due [$];

    int unsigned col_height [PAGE_W] = '{default: 0};
    int unsigned sweep_at      = 0;
    bit          sweeping_back = 1'b0;
    int unsigned pages_open    = 0;
    int unsigned last_page     = 0;

    skyline_block_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void open_fresh_page();
        foreach (col_height[i]) col_height[i] = 0;
        sweep_at      = 0;
        sweeping_back = 1'b0;
        if (pages_open == 0) begin
            col_height[0] = 1;
            sweep_at      = 1;
        end
        pages_open++;
    endfunction

    function automatic bit try_fit(input int unsigned w, input int unsigned h,
                                   output int unsigned fx, output int unsigned fy);
        int unsigned top;
        fx = 0;
        fy = 0;
        if (w > PAGE_W || h > PAGE_H) return 1'b0;
        if (sweeping_back) begin
            if (sweep_at < w) begin
                sweeping_back = 1'b0;
                fx            = 0;
                sweep_at      = w;
            end else begin
                sweep_at -= w;
                fx        = sweep_at;
            end
        end else if (sweep_at + w > PAGE_W) begin
            sweeping_back = 1'b1;
            sweep_at      = PAGE_W - w;
            fx            = sweep_at;
        end else begin
            fx        = sweep_at;
            sweep_at += w;
        end
        top = 0;
        for (int i = 0; i < w; i++) begin
            if (col_height[(fx + i) % PAGE_W] > top) top = col_height[(fx + i) % PAGE_W];
        end
        if (top + h > PAGE_H) return 1'b0;
        for (int i = 0; i < w; i++) col_height[(fx + i) % PAGE_W] = top + h;
        fy = top;
        return 1'b1;
    endfunction

    function automatic alloc_result_t allocate(input logic [7:0] w, input logic [7:0] h);
        alloc_result_t r;
        int unsigned   fx;
        int unsigned   fy;
        bit            ok;
        r  = '0;
        ok = 1'b0;
        fx = 0;
        fy = 0;
        if (w != 0 && h != 0) begin
            if (pages_open > 0) ok = try_fit(w, h, fx, fy);
            while (!ok && pages_open < PAGE_LIMIT) begin
                open_fresh_page();
                ok = try_fit(w, h, fx, fy);
            end
            if (ok) last_page = pages_open - 1;
        end
        if (ok) begin
            r.page_index = last_page[7:0];
            r.pos_x      = fx[6:0];
            r.pos_y      = fy[6:0];
            r.placed     = 1'b1;
        end
        r.pages_used = pages_open[8:0];
        return r;
    endfunction

    function automatic logic [7:0] pick_size(input bit allow_oversize);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3) return 8'd0;
        if (allow_oversize && roll < 8) return 8'($urandom_range(255, 129));
        if (roll < 70) return 8'($urandom_range(16, 1));
        if (roll < 90) return 8'($urandom_range(64, 17));
        return 8'($urandom_range(128, 65));
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_request(input logic [7:0] w, input logic [7:0] h,
                                input logic fixed_result, input alloc_result_t fixed);
        alloc_result_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h, w};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        requests_taken++;
        predicted = allocate(w, h);
        placements_due.insert(placements_due.size(), fixed_result ? fixed : predicted);
    endtask

    task automatic walk_rows(input int first, input int last);
        for (int r = first; r <= last; r++) begin
            send_request(REQUEST_ROWS[r].width, REQUEST_ROWS[r].height,
                         REQUEST_ROWS[r].fixed_result, REQUEST_ROWS[r].result);
        end
    endtask

    task automatic send_random(input int count, input bit allow_oversize);
        repeat (count) send_request(pick_size(allow_oversize), pick_size(allow_oversize), 1'b0, '0);
    endtask

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = alloc_result_t'(m_axis_tdata);
            if (got.placed) placed_seen++;
            else unplaced_seen++;
            if (placements_due.size() == 0) begin
                $error("result item with no request outstanding: %h", m_axis_tdata);
                failures++;
            end else begin
                want = placements_due.pop_front();
                compare_field("page_index", want.page_index, got.page_index);
                compare_field("pos_x", want.pos_x, got.pos_x);
                compare_field("pos_y", want.pos_y, got.pos_y);
                compare_field("placed", want.placed, got.placed);
                compare_field("pages_used", want.pages_used, got.pages_used);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_skyline_block_allocator failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 20;
        take_gap_pct = 79;
        walk_rows(0, N_OPENING - 1);
        send_random(170, 1'b0);

        send_gap_pct = 79;
        take_gap_pct = 20;
        send_random(170, 1'b0);

        // The receiver holds off while requests keep coming, so the block fills and stalls.
        send_gap_pct     = 0;
        take_gap_pct     = 0;
        hold_off_pending = 1'b1;
        send_random(20, 1'b0);

        // Oversized blocks use up every remaining page; only the last page is tried after that.
        walk_rows(N_OPENING, N_ROWS - 1);
        send_random(130, 1'b1);

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        wait (placements_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d requests accepted: %0d placed, %0d refused or not placed.",
                 requests_taken, placed_seen, unplaced_seen);
        $display("Pages opened: %0d of %0d, with a long output stall and all page limits hit.",
                 pages_open, PAGE_LIMIT);
        if (failures == 0) begin
            $display("tb_skyline_block_allocator passed");
        end else begin
            $display("tb_skyline_block_allocator failed");
        end
        $finish;
    end

endmodule
